@@ design/ktc_pkg.sv @@
// ----------------------------------------------------------------------------
// ktc_pkg: shared types and constants for the tracking controller
// Sine polynomial coefficients, gain registers, lane type of the sine chain.
// ----------------------------------------------------------------------------
`default_nettype none
package ktc_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned GAIN_BITS      = 24;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'd65536;

  // Q30 rounding constant and one
  localparam logic [30:0] Q30_ONE  = 31'd1073741824;
  localparam logic [30:0] Q30_HALF = 31'd536870912;

  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598669;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  localparam int unsigned HORNER_STEPS = 4;
  localparam logic [30:0] SIN_COEF [HORNER_STEPS] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

  // fold, square, four Horner cells, final product
  localparam int unsigned SIN_LAT = HORNER_STEPS + 3;

  typedef enum logic [1:0] {
    REG_GAIN_ALONG   = 2'd0,
    REG_GAIN_LATERAL = 2'd1,
    REG_GAIN_HEADING = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [30:0] z;
    logic [30:0] z2;
    logic [30:0] s;
    logic        neg;
  } sin_lane_t;

  // signed product shifted right, magnitude rounded half away from zero
  function automatic logic signed [127:0] rshr_mag(input logic signed [127:0] p,
                                                   input int unsigned sh);
    logic [127:0] mag;
    logic [127:0] r;
    mag = p[127] ? 128'(-p) : 128'(p);
    r   = (mag + (128'(1) << (sh - 1))) >> sh;
    return p[127] ? -signed'(r) : signed'(r);
  endfunction

endpackage
`default_nettype wire

@@ design/kanayama_tracking_control.sv @@
// ----------------------------------------------------------------------------
// kanayama_tracking_control: pose tracking law, pipelined
// Rotates the pose error into the robot frame and forms saturated v and w.
//
// channel   dir  fields
// s_axis    in   target/actual pose, target speed and turn rate
// m_axis    out  drive_speed, drive_turn_rate
// cfg       in   gain_along, gain_lateral, gain_heading
//
// One request per cycle while the output is not stalled; 7 sine stages, 6 math stages.
// All stages advance together; m_axis_tready low with a valid output freezes the whole pipe.
// Reset clears stage valids and sets gains to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none
module kanayama_tracking_control #(
  parameter int unsigned ANGLE_BITS = ktc_pkg::ANGLE_BITS_DEF,
  parameter int unsigned VALUE_BITS = ktc_pkg::VALUE_BITS_DEF,
  localparam int unsigned IN_W  = ((6 * VALUE_BITS + 2 * ANGLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // target_x, target_y, target_heading, actual_x, actual_y, actual_heading,
  // target_speed, target_turn_rate
  input  wire logic [IN_W-1:0]               s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // drive_speed, drive_turn_rate
  output logic [OUT_W-1:0]                   m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [ktc_pkg::GAIN_BITS-1:0] cfg_data_i
);

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned AB = ANGLE_BITS;
  localparam int unsigned LAT = ktc_pkg::SIN_LAT;
  localparam int unsigned DEPTH = LAT + 6;
  localparam int unsigned DW = VB + 1;
  localparam int unsigned EW = DW + 1;
  localparam int unsigned GW = EW + 9;
  localparam int unsigned SW = GW + 1;
  localparam int unsigned PW = VB + SW;
  localparam int unsigned RW = PW - 15;
  localparam int unsigned WW = RW + 1;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

  localparam int unsigned O_TY  = VB;
  localparam int unsigned O_THR = 2 * VB;
  localparam int unsigned O_AX  = 2 * VB + AB;
  localparam int unsigned O_AY  = 3 * VB + AB;
  localparam int unsigned O_THC = 4 * VB + AB;
  localparam int unsigned O_VR  = 4 * VB + 2 * AB;
  localparam int unsigned O_WR  = 5 * VB + 2 * AB;

  function automatic logic [VB-1:0] sat_value(input logic signed [127:0] x);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (VB - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (x > hi) begin
      return hi[VB-1:0];
    end else if (x < lo) begin
      return lo[VB-1:0];
    end
    return x[VB-1:0];
  endfunction

  // configuration
  logic [ktc_pkg::GAIN_BITS-1:0] gain_along_q, gain_lateral_q, gain_heading_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_along_q   <= ktc_pkg::GAIN_RESET;
      gain_lateral_q <= ktc_pkg::GAIN_RESET;
      gain_heading_q <= ktc_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ktc_pkg::REG_GAIN_ALONG:   gain_along_q   <= cfg_data_i;
        ktc_pkg::REG_GAIN_LATERAL: gain_lateral_q <= cfg_data_i;
        ktc_pkg::REG_GAIN_HEADING: gain_heading_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake and stage valids
  logic             en;
  logic [DEPTH-1:0] vld_d, vld_q;

  assign en            = !vld_q[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[DEPTH-1];
  assign vld_d         = {vld_q[DEPTH-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // input unpack
  logic signed [VB-1:0] tx, ty, ax, ay, vr_in, wr_in;
  logic [AB-1:0]        thr, thc, te;

  assign tx    = s_axis_tdata[VB-1:0];
  assign ty    = s_axis_tdata[O_TY +: VB];
  assign thr   = s_axis_tdata[O_THR +: AB];
  assign ax    = s_axis_tdata[O_AX +: VB];
  assign ay    = s_axis_tdata[O_AY +: VB];
  assign thc   = s_axis_tdata[O_THC +: AB];
  assign vr_in = s_axis_tdata[O_VR +: VB];
  assign wr_in = s_axis_tdata[O_WR +: VB];
  assign te    = thr - thc;

  // sines of measured heading and heading error
  logic signed [31:0] sc, cc, st, ct;

  ktc_sine #(.ANGLE_BITS(AB)) u_sin_c (
    .clk_i(clk_i), .en_i(en), .angle_i(thc), .sin_o(sc)
  );
  ktc_sine #(.ANGLE_BITS(AB)) u_cos_c (
    .clk_i(clk_i), .en_i(en), .angle_i(thc + QUARTER), .sin_o(cc)
  );
  ktc_sine #(.ANGLE_BITS(AB)) u_sin_t (
    .clk_i(clk_i), .en_i(en), .angle_i(te), .sin_o(st)
  );
  ktc_sine #(.ANGLE_BITS(AB)) u_cos_t (
    .clk_i(clk_i), .en_i(en), .angle_i(te + QUARTER), .sin_o(ct)
  );

  // delay lines matching the sine latency and the later math stages
  logic signed [DW-1:0] dx_dl [LAT];
  logic signed [DW-1:0] dy_dl [LAT];
  logic signed [VB-1:0] vr_dl [LAT + 4];
  logic signed [VB-1:0] wr_dl [LAT + 5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_dl[0] <= DW'(tx) - DW'(ax);
      dy_dl[0] <= DW'(ty) - DW'(ay);
      vr_dl[0] <= vr_in;
      wr_dl[0] <= wr_in;
      for (int i = 1; i < LAT; i++) begin
        dx_dl[i] <= dx_dl[i-1];
        dy_dl[i] <= dy_dl[i-1];
      end
      for (int i = 1; i < LAT + 4; i++) begin
        vr_dl[i] <= vr_dl[i-1];
      end
      for (int i = 1; i < LAT + 5; i++) begin
        wr_dl[i] <= wr_dl[i-1];
      end
    end
  end

  // stage 1: rotation and sine products
  logic signed [DW+31:0] m_dxc, m_dys, m_dyc, m_dxs, m_vct;
  logic signed [57:0]    m_ghst;
  logic signed [DW-1:0]  p_dxc_q, p_dys_q, p_dyc_q, p_dxs_q, p_vct_q;
  logic signed [25:0]    p_ghst_q;

  assign m_dxc  = dx_dl[LAT-1] * cc;
  assign m_dys  = dy_dl[LAT-1] * sc;
  assign m_dyc  = dy_dl[LAT-1] * cc;
  assign m_dxs  = dx_dl[LAT-1] * sc;
  assign m_vct  = (DW+32)'(vr_dl[LAT-1]) * (DW+32)'(ct);
  assign m_ghst = 58'(signed'({1'b0, gain_heading_q})) * 58'(st);

  // stage 2: frame errors
  logic signed [EW-1:0] xe_q, ye_q;
  logic signed [DW-1:0] vct2_q;
  logic signed [25:0]   ghst2_q;

  // stage 3: gain products
  logic signed [EW+24:0] m_gaxe, m_glye;
  logic signed [GW-1:0]  gaxe_q, glye_q;
  logic signed [DW-1:0]  vct3_q;
  logic signed [25:0]    ghst3_q;

  assign m_gaxe = (EW+25)'(signed'({1'b0, gain_along_q})) * (EW+25)'(xe_q);
  assign m_glye = (EW+25)'(signed'({1'b0, gain_lateral_q})) * (EW+25)'(ye_q);

  // stage 4: sums
  logic signed [SW-1:0] v_q, inner_q;

  // stage 5: speed times inner term
  logic signed [PW-1:0] m_vin;
  logic signed [RW-1:0] vin_q;
  logic signed [SW-1:0] v5_q;

  assign m_vin = PW'(vr_dl[LAT+3]) * PW'(inner_q);

  // stage 6: output
  logic signed [WW-1:0] w_sum;
  logic [VB-1:0]        spd_q, trn_q;

  assign w_sum = WW'(wr_dl[LAT+4]) + WW'(vin_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_dxc_q  <= DW'(ktc_pkg::rshr_mag(128'(m_dxc), 30));
      p_dys_q  <= DW'(ktc_pkg::rshr_mag(128'(m_dys), 30));
      p_dyc_q  <= DW'(ktc_pkg::rshr_mag(128'(m_dyc), 30));
      p_dxs_q  <= DW'(ktc_pkg::rshr_mag(128'(m_dxs), 30));
      p_vct_q  <= DW'(ktc_pkg::rshr_mag(128'(m_vct), 30));
      p_ghst_q <= 26'(ktc_pkg::rshr_mag(128'(m_ghst), 30));

      xe_q    <= EW'(p_dxc_q) + EW'(p_dys_q);
      ye_q    <= EW'(p_dyc_q) - EW'(p_dxs_q);
      vct2_q  <= p_vct_q;
      ghst2_q <= p_ghst_q;

      gaxe_q  <= GW'(ktc_pkg::rshr_mag(128'(m_gaxe), 16));
      glye_q  <= GW'(ktc_pkg::rshr_mag(128'(m_glye), 16));
      vct3_q  <= vct2_q;
      ghst3_q <= ghst2_q;

      v_q     <= SW'(vct3_q) + SW'(gaxe_q);
      inner_q <= SW'(glye_q) + SW'(ghst3_q);

      vin_q   <= RW'(ktc_pkg::rshr_mag(128'(m_vin), 16));
      v5_q    <= v_q;

      spd_q   <= sat_value(128'(v5_q));
      trn_q   <= sat_value(128'(w_sum));
    end
  end

  assign m_axis_tdata = OUT_W'({trn_q, spd_q});

  // checks
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_sine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAT-1] |-> (cc <= 32'sd1073741824 && cc >= -32'sd1073741824 &&
                      st <= 32'sd1073741824 && st >= -32'sd1073741824))
    else $error("sine out of range");

endmodule
`default_nettype wire

@@ design/ktc_horner_cell.sv @@
// ----------------------------------------------------------------------------
// ktc_horner_cell: one Horner step of the quarter-wave sine polynomial
// s_out = COEF - round(z2 * s_in / 2^30); lane handed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module ktc_horner_cell #(
  parameter logic [30:0] COEF = ktc_pkg::SIN_C1
) (
  input  wire                logic clk_i,
  input  wire                logic en_i,
  input  ktc_pkg::sin_lane_t lane_i,
  output ktc_pkg::sin_lane_t lane_o
);

  logic [61:0]        prod;
  logic [61:0]        rnd;
  ktc_pkg::sin_lane_t lane_d, lane_q;

  always_comb begin
    prod   = 62'(lane_i.z2) * 62'(lane_i.s);
    rnd    = (prod + 62'(ktc_pkg::Q30_HALF)) >> 30;
    lane_d = lane_i;
    lane_d.s = COEF - rnd[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule
`default_nettype wire

@@ design/ktc_sine.sv @@
// ----------------------------------------------------------------------------
// ktc_sine: pipelined sine of a binary angle, Q30 signed result
// Quadrant fold, square, chain of Horner cells, final product and clamp.
// ----------------------------------------------------------------------------
`default_nettype none
module ktc_sine #(
  parameter int unsigned ANGLE_BITS = ktc_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [ANGLE_BITS-1:0] angle_i,
  output logic signed [31:0]         sin_o
);

  localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);

  logic [1:0]            quad;
  logic [ANGLE_BITS-2:0] rr;
  ktc_pkg::sin_lane_t    fold_d, fold_q, sq_d, sq_q;
  ktc_pkg::sin_lane_t    chain [ktc_pkg::HORNER_STEPS+1];
  logic [61:0]           zz, zs, zs_r;
  logic [30:0]           res;
  logic signed [31:0]    sin_d, sin_q;

  always_comb begin
    quad   = angle_i[ANGLE_BITS-1:ANGLE_BITS-2];
    rr     = {1'b0, angle_i[ANGLE_BITS-3:0]};
    if (quad[0]) begin
      rr = QUARTER - rr;
    end
    fold_d     = '0;
    fold_d.z   = 31'(rr) << (32 - ANGLE_BITS);
    fold_d.neg = quad[1];
  end

  always_comb begin
    zz      = 62'(fold_q.z) * 62'(fold_q.z);
    sq_d    = fold_q;
    sq_d.z2 = 31'((zz + 62'(ktc_pkg::Q30_HALF)) >> 30);
    sq_d.s  = ktc_pkg::SIN_C9;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q <= fold_d;
      sq_q   <= sq_d;
      sin_q  <= sin_d;
    end
  end

  assign chain[0] = sq_q;

  for (genvar k = 0; k < ktc_pkg::HORNER_STEPS; k++) begin : g_cell
    ktc_horner_cell #(
      .COEF(ktc_pkg::SIN_COEF[k])
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .lane_i(chain[k]),
      .lane_o(chain[k+1])
    );
  end

  always_comb begin
    zs   = 62'(chain[ktc_pkg::HORNER_STEPS].z) * 62'(chain[ktc_pkg::HORNER_STEPS].s);
    zs_r = (zs + 62'(ktc_pkg::Q30_HALF)) >> 30;
    res  = (zs_r > 62'(ktc_pkg::Q30_ONE)) ? ktc_pkg::Q30_ONE : zs_r[30:0];
    sin_d = chain[ktc_pkg::HORNER_STEPS].neg ? -signed'(32'(res)) : signed'(32'(res));
  end

  assign sin_o = sin_q;

endmodule
`default_nettype wire

@@ verif/kanayama_tracking_control_tb.sv @@
// ----------------------------------------------------------------------------
// kanayama_tracking_control_tb: self-checking bench for the tracking law
// Streams pose samples with random gaps and output stalls, predicts the
// saturated drive speed and turn rate per request and checks them in order.
// Gains are rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none
module kanayama_tracking_control_tb;

  localparam int unsigned AB = 16;
  localparam int unsigned IN_W = 224;
  localparam int unsigned OUT_W = 64;
  localparam int unsigned PIPE_LAT = 13;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct packed {
    logic [31:0] turn;
    logic [31:0] speed;
    logic [15:0] ah;
    logic [31:0] ay;
    logic [31:0] ax;
    logic [15:0] th;
    logic [31:0] ty;
    logic [31:0] tx;
  } pose_t;

  typedef struct {
    logic [31:0] drive_speed;
    logic [31:0] drive_turn_rate;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [ktc_pkg::GAIN_BITS-1:0] cfg_data_i = '0;

  kanayama_tracking_control DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_index_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  logic [23:0] k_along = 24'd65536;
  logic [23:0] k_lateral = 24'd65536;
  logic [23:0] k_heading = 24'd65536;

  pose_t pending_poses[$];
  drive_t expected_drives[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [IN_W-1:0] pack_pose(pose_t p);
    return {p.turn, p.speed, p.ah, p.ay, p.ax, p.th, p.ty, p.tx};
  endfunction

  // rounded product of magnitudes, sign restored, capped at 2^61
  function automatic longint mul_round(longint a, longint b, int sh);
    logic [127:0] ma, mb, pr;
    bit neg;
    longint r;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? 128'(-a) : 128'(a);
    mb = b < 0 ? 128'(-b) : 128'(b);
    pr = (ma * mb + (128'(1) << (sh - 1))) >> sh;
    if (pr > (128'(1) << 61)) pr = 128'(1) << 61;
    r = longint'(pr);
    return neg ? -r : r;
  endfunction

  function automatic longint quarter_sin(logic [63:0] r);
    logic [63:0] z, z2, s, res;
    z = r << (32 - AB);
    z2 = (z * z + 64'd536870912) >> 30;
    s = 64'd172272;
    s = 64'd5026995 - ((z2 * s + 64'd536870912) >> 30);
    s = 64'd85569306 - ((z2 * s + 64'd536870912) >> 30);
    s = 64'd693598669 - ((z2 * s + 64'd536870912) >> 30);
    s = 64'd1686629713 - ((z2 * s + 64'd536870912) >> 30);
    res = (z * s + 64'd536870912) >> 30;
    if (res > 64'd1073741824) res = 64'd1073741824;
    return longint'(res);
  endfunction

  function automatic longint bam_sin(logic [15:0] a);
    logic [13:0] r;
    longint s;
    r = a[13:0];
    s = quarter_sin(a[14] ? 64'd16384 - r : 64'(r));
    return a[15] ? -s : s;
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic drive_t tracking_law(pose_t p);
    longint dx, dy, cc, sc, ct, st, xe, ye, v, inner, w, vr;
    logic [15:0] te;
    drive_t d;
    dx = longint'($signed(p.tx)) - longint'($signed(p.ax));
    dy = longint'($signed(p.ty)) - longint'($signed(p.ay));
    cc = bam_sin(p.ah + 16'd16384);
    sc = bam_sin(p.ah);
    te = p.th - p.ah;
    ct = bam_sin(te + 16'd16384);
    st = bam_sin(te);
    vr = longint'($signed(p.speed));
    xe = mul_round(dx, cc, 30) + mul_round(dy, sc, 30);
    ye = mul_round(dy, cc, 30) - mul_round(dx, sc, 30);
    v = mul_round(vr, ct, 30) + mul_round(longint'(k_along), xe, 16);
    inner = mul_round(longint'(k_lateral), ye, 16) + mul_round(longint'(k_heading), st, 30);
    w = longint'($signed(p.turn)) + mul_round(vr, inner, 16);
    d.drive_speed = clamp32(v);
    d.drive_turn_rate = clamp32(w);
    return d;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // driver
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) expected_drives.push_back(tracking_law(pose_t'(s_axis_tdata)));
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_poses.size() > 0) begin
          s_axis_tdata <= pack_pose(pending_poses.pop_front());
          s_axis_tvalid <= 1'b1;
          send_gap = gap_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // struct field order mirrors tdata (lowest field last in the struct)
  // so pose_t'(tdata) needs the struct laid out the same way
  // monitor
  int unsigned recv_gap = 0;
  always @(posedge clk_i) begin
    drive_t want;
    logic [31:0] got_v, got_w;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got_v = m_axis_tdata[31:0];
        got_w = m_axis_tdata[63:32];
        if (expected_drives.size() == 0) begin
          report("unexpected result", got_v, 32'h0);
        end else begin
          want = expected_drives.pop_front();
          if (got_v !== want.drive_speed) report("drive_speed", got_v, want.drive_speed);
          if (got_w !== want.drive_turn_rate)
            report("drive_turn_rate", got_w, want.drive_turn_rate);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("kanayama_tracking_control_tb: done, errors");
      $finish;
    end
  end

  function automatic pose_t rand_pose(bit wild);
    pose_t p;
    p.th = 16'($urandom);
    p.ah = 16'($urandom);
    if (wild) begin
      p.tx = $urandom; p.ty = $urandom; p.ax = $urandom; p.ay = $urandom;
      p.speed = $urandom; p.turn = $urandom;
    end else begin
      p.ax = 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
      p.ay = 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
      p.tx = p.ax + 32'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000);
      p.ty = p.ay + 32'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000);
      p.speed = 32'($signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000);
      p.turn = 32'($signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000);
    end
    return p;
  endfunction

  // sample after the edge settles so a request launched at that edge is seen
  task automatic drain();
    while (pending_poses.size() > 0 || s_axis_tvalid || expected_drives.size() > 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_gain(ktc_pkg::cfg_reg_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ktc_pkg::REG_GAIN_ALONG: k_along = val;
      ktc_pkg::REG_GAIN_LATERAL: k_lateral = val;
      default: k_heading = val;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    pose_t p;
    logic [31:0] ext[4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, heading quadrant edges, wrap of heading error
    for (int i = 0; i < 4; i++) begin
      p = '{turn: ext[i], speed: ext[i], ay: ext[3-i], ax: ext[(i+1)%4],
            ty: ext[(i+2)%4], tx: ext[i], ah: 16'(i * 16'h4000), th: 16'h8000};
      pending_poses.push_back(p);
    end
    foreach (ext[i]) begin
      p = rand_pose(1'b0);
      p.th = 16'h7fff; p.ah = 16'h8000;
      pending_poses.push_back(p);
      p.th = 16'(i * 16'h4000); p.ah = 16'h0000;
      p.speed = 32'h00010000;
      pending_poses.push_back(p);
    end
    p = '{turn: 32'h7fffffff, speed: 32'h7fffffff, ay: 32'h80000000, ax: 32'h80000000,
          ty: 32'h7fffffff, tx: 32'h7fffffff, ah: 16'h2000, th: 16'h6000};
    pending_poses.push_back(p);
    drain();
    write_gain(ktc_pkg::REG_GAIN_ALONG, 24'hffffff);
    write_gain(ktc_pkg::REG_GAIN_LATERAL, 24'hffffff);
    write_gain(ktc_pkg::REG_GAIN_HEADING, 24'hffffff);
    for (int i = 0; i < 6; i++) pending_poses.push_back(rand_pose(i[0]));
    drain();
    write_gain(ktc_pkg::REG_GAIN_ALONG, 24'h0);
    write_gain(ktc_pkg::REG_GAIN_LATERAL, 24'h0);
    write_gain(ktc_pkg::REG_GAIN_HEADING, 24'h0);
    for (int i = 0; i < 6; i++) pending_poses.push_back(rand_pose(i[0]));
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_gain(ktc_pkg::REG_GAIN_ALONG, 24'($urandom_range(0, 24'h3ffff)));
      write_gain(ktc_pkg::REG_GAIN_LATERAL, 24'($urandom));
      write_gain(ktc_pkg::REG_GAIN_HEADING, 24'($urandom_range(0, 24'h3ffff)));
      for (int i = 0; i < 110; i++)
        pending_poses.push_back(rand_pose($urandom_range(0, 4) == 0));
      drain();
    end
    if (errors == 0) begin
      $display("kanayama_tracking_control_tb: done, clean");
    end else begin
      $display("kanayama_tracking_control_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
